### src/server_select_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef SERVER_SELECT_SCHEDULER_UNIT_ASSERT_SVH
`define SERVER_SELECT_SCHEDULER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked through reset.
`define SSS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

### src/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants of the server select scheduler.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int CNT_W   = 32;
  localparam int VAL_W   = 16;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 5;
  localparam int CFG_W   = 5;

  localparam logic [1:0] CMD_SELECT  = 2'd0;
  localparam logic [1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [1:0] CMD_SESSION = 2'd2;

  localparam logic [1:0] MODE_RR    = 2'd0;
  localparam logic [1:0] MODE_WRR   = 2'd1;
  localparam logic [1:0] MODE_LEAST = 2'd2;
  localparam logic [1:0] MODE_HASH  = 2'd3;

  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef enum logic [1:0] {
    K_SELECT,
    K_WEIGHT,
    K_SESSION
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SLOT_W-1:0]  slot;
    logic [VAL_W-1:0]   value;
    logic [CNT_W-1:0]   addr;
  } req_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_WALK,
    B_MIN,
    B_OUT
  } bstate_t;

endpackage

### src/sss_ram.sv
// ----------------------------------------------------------------------------
// sss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/sss_div.sv
// ----------------------------------------------------------------------------
// sss_div
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sss_div #(
  parameter int DW = 21
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [sss_pkg::CNT_W-1:0] dividend,
  input  logic [DW-1:0]           divisor,
  output logic                    done,
  output logic [DW-1:0]           rem
);

  localparam int STEP_W = $clog2(sss_pkg::CNT_W);

  logic                      busy;
  logic [STEP_W-1:0]         step;
  logic [sss_pkg::CNT_W-1:0] dvd;
  logic [DW-1:0]             dsr;
  logic [DW:0]               trial;
  logic [DW-1:0]             rem_next;

  always_comb begin
    trial = {rem, dvd[sss_pkg::CNT_W-1]};
    if (trial >= {1'b0, dsr}) begin
      rem_next = DW'(trial - {1'b0, dsr});
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        dvd  <= dvd << 1;
        rem  <= rem_next;
        step <= step + 1'b1;
        if (step == STEP_W'(sss_pkg::CNT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/sss_front.sv
// ----------------------------------------------------------------------------
// sss_front
// Accepts requests, drops those with no effect, queues the rest (2 deep).
// ----------------------------------------------------------------------------
module sss_front #(
  parameter int MAX_SERVERS = sss_pkg::MAX_SERVERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [sss_pkg::SLOT_W-1:0]  server_slot,
  input  logic [sss_pkg::VAL_W-1:0]   value,
  input  logic [sss_pkg::CNT_W-1:0]   client_addr,
  output logic                        q_valid,
  output sss_pkg::req_t               q_req,
  input  logic                        q_pop
);

  sss_pkg::req_t q_mem [2];
  logic          wp;
  logic          rp;
  logic [1:0]    cnt;
  logic          keep;
  logic          push;
  logic          pop;
  sss_pkg::req_t req;

  always_comb begin
    req.slot  = server_slot;
    req.value = value;
    req.addr  = client_addr;
    req.kind  = sss_pkg::K_SELECT;
    keep      = 1'b0;
    case (cmd)
      sss_pkg::CMD_SELECT: begin
        keep = 1'b1;
      end
      sss_pkg::CMD_WEIGHT: begin
        req.kind = sss_pkg::K_WEIGHT;
        keep     = 32'(server_slot) < MAX_SERVERS;
      end
      sss_pkg::CMD_SESSION: begin
        req.kind = sss_pkg::K_SESSION;
        keep     = 32'(server_slot) < MAX_SERVERS;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt != 2'd0);
  assign q_req    = q_mem[rp];
  assign pop      = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wp] <= req;
        wp        <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### src/sss_back.sv
// ----------------------------------------------------------------------------
// sss_back
// Executes queued requests: table writes and the server select sequencer.
// ----------------------------------------------------------------------------
module sss_back #(
  parameter int MAX_SERVERS = sss_pkg::MAX_SERVERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  mode,
  input  logic [sss_pkg::COUNT_W-1:0] server_count,
  input  logic                        q_valid,
  input  sss_pkg::req_t               q_req,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [sss_pkg::SLOT_W-1:0]  chosen_server
);

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int TW = sss_pkg::VAL_W + $clog2(MAX_SERVERS + 1);
  localparam int CW = sss_pkg::COUNT_W;

  sss_pkg::bstate_t state;
  sss_pkg::bstate_t state_next;

  logic [sss_pkg::CNT_W-1:0]  rot_cnt;
  logic [CW-1:0]              n;
  logic [CW-1:0]              idx;
  logic                       pend;
  logic [AW-1:0]              pend_addr;
  logic [sss_pkg::SLOT_W-1:0] pend_slot;
  logic [TW-1:0]              total;
  logic [TW-1:0]              pos;
  logic [sss_pkg::VAL_W:0]    best;
  logic                       res_found;
  logic [sss_pkg::SLOT_W-1:0] res_slot;

  logic [MAX_SERVERS-1:0]     w_vld;
  logic [MAX_SERVERS-1:0]     s_vld;
  logic [sss_pkg::VAL_W-1:0]  w_q;
  logic [sss_pkg::VAL_W-1:0]  s_q;
  logic [sss_pkg::VAL_W-1:0]  rd_w;
  logic [sss_pkg::VAL_W-1:0]  rd_s;

  logic                       w_we;
  logic                       s_we;
  logic                       issue;
  logic                       walk_end;
  logic                       out_free;
  logic                       div_start;
  logic                       div_done;
  logic [sss_pkg::CNT_W-1:0]  div_dvd;
  logic [TW-1:0]              div_dsr;
  logic [TW-1:0]              div_rem;
  logic                       is_sel;

  // Counts above the table depth clamp to the depth.
  assign n = (32'(server_count) > MAX_SERVERS) ? CW'(MAX_SERVERS) : server_count;

  assign rd_w = w_vld[pend_addr] ? w_q : '0;
  assign rd_s = s_vld[pend_addr] ? s_q : '0;

  sss_ram #(.WIDTH(sss_pkg::VAL_W), .DEPTH(MAX_SERVERS)) u_weight (
    .clk   (clk),
    .we    (w_we),
    .waddr (AW'(q_req.slot)),
    .wdata (q_req.value),
    .raddr (AW'(idx)),
    .rdata (w_q)
  );

  sss_ram #(.WIDTH(sss_pkg::VAL_W), .DEPTH(MAX_SERVERS)) u_session (
    .clk   (clk),
    .we    (s_we),
    .waddr (AW'(q_req.slot)),
    .wdata (q_req.value),
    .raddr (AW'(idx)),
    .rdata (s_q)
  );

  assign div_dvd = (mode == sss_pkg::MODE_HASH) ? q_req.addr : rot_cnt;
  assign div_dsr = (mode == sss_pkg::MODE_WRR) ? total : TW'(n);

  sss_div #(.DW(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign walk_end = !pend && (idx >= n);
  assign out_free = !out_valid || !out_stall;
  assign is_sel   = q_valid && (q_req.kind == sss_pkg::K_SELECT);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sss_pkg::B_IDLE: begin
        if (is_sel) begin
          if (n == '0) begin
            state_next = sss_pkg::B_OUT;
          end else begin
            case (mode)
              sss_pkg::MODE_WRR:   state_next = sss_pkg::B_SUM;
              sss_pkg::MODE_LEAST: state_next = sss_pkg::B_MIN;
              default:             state_next = sss_pkg::B_DIV;
            endcase
          end
        end
      end
      sss_pkg::B_SUM: begin
        if (walk_end) begin
          state_next = (total == '0) ? sss_pkg::B_OUT : sss_pkg::B_DIV;
        end
      end
      sss_pkg::B_DIV: begin
        if (div_done) begin
          state_next = (mode == sss_pkg::MODE_WRR) ? sss_pkg::B_WALK : sss_pkg::B_OUT;
        end
      end
      sss_pkg::B_WALK: begin
        if ((pend && (pos < TW'(rd_w))) || walk_end) begin
          state_next = sss_pkg::B_OUT;
        end
      end
      sss_pkg::B_MIN: begin
        if (walk_end) begin
          state_next = sss_pkg::B_OUT;
        end
      end
      sss_pkg::B_OUT: begin
        if (out_free) begin
          state_next = sss_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = sss_pkg::B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    w_we      = 1'b0;
    s_we      = 1'b0;
    issue     = 1'b0;
    div_start = 1'b0;
    case (state)
      sss_pkg::B_IDLE: begin
        q_pop     = q_valid;
        w_we      = q_valid && (q_req.kind == sss_pkg::K_WEIGHT);
        s_we      = q_valid && (q_req.kind == sss_pkg::K_SESSION);
        div_start = is_sel && (n != '0) &&
                    ((mode == sss_pkg::MODE_RR) || (mode == sss_pkg::MODE_HASH));
      end
      sss_pkg::B_SUM: begin
        issue     = idx < n;
        div_start = walk_end && (total != '0);
      end
      sss_pkg::B_WALK, sss_pkg::B_MIN: begin
        issue = idx < n;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sss_pkg::B_IDLE;
      rot_cnt <= '0;
      w_vld   <= '0;
      s_vld   <= '0;
      pend    <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= issue;
      pend_addr <= AW'(idx);
      pend_slot <= idx[sss_pkg::SLOT_W-1:0];
      if (issue) begin
        idx <= idx + 1'b1;
      end
      if (w_we) begin
        w_vld[AW'(q_req.slot)] <= 1'b1;
      end
      if (s_we) begin
        s_vld[AW'(q_req.slot)] <= 1'b1;
      end
      case (state)
        sss_pkg::B_IDLE: begin
          idx       <= '0;
          total     <= '0;
          best      <= '1;
          res_slot  <= '0;
          res_found <= (mode == sss_pkg::MODE_LEAST) && (n != '0);
        end
        sss_pkg::B_SUM: begin
          if (pend) begin
            total <= total + TW'(rd_w);
          end
        end
        sss_pkg::B_DIV: begin
          idx <= '0;
          if (div_done) begin
            if ((mode == sss_pkg::MODE_RR) || (mode == sss_pkg::MODE_WRR)) begin
              rot_cnt <= rot_cnt + 1'b1;
            end
            if (mode == sss_pkg::MODE_WRR) begin
              pos <= div_rem;
            end else begin
              res_found <= 1'b1;
              res_slot  <= div_rem[sss_pkg::SLOT_W-1:0];
            end
          end
        end
        sss_pkg::B_WALK: begin
          if (pend) begin
            if (pos < TW'(rd_w)) begin
              res_found <= 1'b1;
              res_slot  <= pend_slot;
            end else begin
              pos <= pos - TW'(rd_w);
            end
          end
        end
        sss_pkg::B_MIN: begin
          // strict less-than keeps the lowest slot on ties
          if (pend && ({1'b0, rd_s} < best)) begin
            best     <= {1'b0, rd_s};
            res_slot <= pend_slot;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == sss_pkg::B_OUT) && out_free) begin
      out_valid     <= 1'b1;
      found         <= res_found;
      chosen_server <= res_slot;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/server_select_scheduler_unit.sv
// A select request returns one result; weight and session writes return none
// and are written to their table as the back end pops them. Round robin and
// source hash selects run the remainder unit once. Weighted round robin (N active
// servers) makes one pass over the weight RAM to sum, the remainder step, then a
// second pass to walk the weights, one entry a cycle. Least sessions makes one
// pass over the session RAM.
// A two-entry request queue lets the front keep accepting while a select runs.
// ----------------------------------------------------------------------------
// server_select_scheduler_unit
// Picks an active server per select request under a configurable policy.
// ----------------------------------------------------------------------------
`include "server_select_scheduler_unit_assert.svh"

module server_select_scheduler_unit #(
  parameter int MAX_SERVERS = sss_pkg::MAX_SERVERS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sss_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  cmd,
  input  logic [sss_pkg::SLOT_W-1:0]  server_slot,
  input  logic [sss_pkg::VAL_W-1:0]   value,
  input  logic [sss_pkg::CNT_W-1:0]   client_addr,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [sss_pkg::SLOT_W-1:0]  chosen_server
);

  logic [1:0]                  mode;
  logic [sss_pkg::COUNT_W-1:0] server_count;
  logic                        q_valid;
  logic                        q_pop;
  sss_pkg::req_t               q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= sss_pkg::MODE_RR;
      server_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == sss_pkg::REG_MODE) begin
        mode <= cfg_data[1:0];
      end else begin
        server_count <= cfg_data;
      end
    end
  end

  sss_front #(.MAX_SERVERS(MAX_SERVERS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .server_slot (server_slot),
    .value       (value),
    .client_addr (client_addr),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_pop       (q_pop)
  );

  sss_back #(.MAX_SERVERS(MAX_SERVERS)) u_back (
    .clk           (clk),
    .rst           (rst),
    .mode          (mode),
    .server_count  (server_count),
    .q_valid       (q_valid),
    .q_req         (q_req),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .chosen_server (chosen_server)
  );

  `SSS_ASSERT_NOW(a_miss_zero, out_valid && !found, chosen_server == '0, "miss with nonzero slot")
  `SSS_ASSERT_NOW(a_hit_active, out_valid && found, {1'b0, chosen_server} < server_count, "slot not active")
  `SSS_ASSERT_ALWAYS(a_rst_out, $past(rst), !out_valid, "result valid after reset")

endmodule
